>>> hdl/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg: shared types and codes for the API frame receive parser and
// transmit framer.
// ----------------------------------------------------------------------------
package afp_pkg;

    // Input item kinds as they arrive on the port.
    localparam logic [1:0] KIND_RX      = 2'd0;
    localparam logic [1:0] KIND_BEGIN   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Result kinds.
    localparam logic [1:0] OUT_SEND    = 2'd0;
    localparam logic [1:0] OUT_PAYLOAD = 2'd1;
    localparam logic [1:0] OUT_STATUS  = 2'd2;

    // Receive status codes.
    localparam logic [1:0] ST_PASS     = 2'd0;
    localparam logic [1:0] ST_CHKFAIL  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELIMITER = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_FRAME_TYPE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_FRAME_TYPE   = 4'd3;

    localparam logic [15:0] RST_MAX_PAYLOAD     = 16'd0;
    localparam logic [7:0]  RST_START_DELIMITER = 8'h7E;
    localparam logic [7:0]  RST_RX_FRAME_TYPE   = 8'h90;
    localparam logic [7:0]  RST_TX_FRAME_TYPE   = 8'h10;

    // Fixed frame constants.
    localparam logic [7:0]  CHECK_TARGET   = 8'hFF;
    localparam logic [15:0] TX_HEADER_LEN  = 16'd14;
    localparam logic [15:0] RX_PAYLOAD_OFS = 16'd12;
    localparam logic [7:0]  PAD_BYTE       = 8'h00;

    // Classified operation passed from the front to the back.
    typedef enum logic [1:0] {
        OP_RX    = 2'd0,
        OP_BEGIN = 2'd1,
        OP_PAY   = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [15:0] count;
    } t_item;

    typedef struct packed {
        logic [15:0] max_payload;
        logic [7:0]  start_delimiter;
        logic [7:0]  rx_frame_type;
        logic [7:0]  tx_frame_type;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_val;
        logic [1:0]  status;
        logic [15:0] count;
        logic        last;
    } t_result;

    // Queue status towards the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

>>> hdl/api_frame_rx_parser_tx_framer.sv
// ----------------------------------------------------------------------------
// api_frame_rx_parser_tx_framer: API frame receive parser and transmit framer
// An item passes the input register and the queue before its result is registered.
// Throughput: one item per cycle without stalls; the last payload byte of a frame
// adds its checksum byte, and a begin item holds the unit for its header sequence.
// Reset: synchronous, active low; clears the queue, the parser and framer
// state and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module api_frame_rx_parser_tx_framer
    import afp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_kind,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_tx_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_out_kind,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_status,
    output logic [15:0]          o_payload_count,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg          r_cfg;
    t_item         w_push_item;
    t_item         w_pop_item;
    logic          w_push;
    logic          w_pop;
    logic          w_busy;
    t_queue_status w_queue;
    t_result       w_result;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] w_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_payload     <= RST_MAX_PAYLOAD;
            r_cfg.start_delimiter <= RST_START_DELIMITER;
            r_cfg.rx_frame_type   <= RST_RX_FRAME_TYPE;
            r_cfg.tx_frame_type   <= RST_TX_FRAME_TYPE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_PAYLOAD:     r_cfg.max_payload     <= i_cfg_data;
                CFG_START_DELIMITER: r_cfg.start_delimiter <= i_cfg_data[7:0];
                CFG_RX_FRAME_TYPE:   r_cfg.rx_frame_type   <= i_cfg_data[7:0];
                CFG_TX_FRAME_TYPE:   r_cfg.tx_frame_type   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    afp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_tx_count  (i_tx_count),
        .i_queue     (w_queue),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    afp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_pop_item),
        .o_status (w_queue),
        .o_level  (w_level)
    );

    afp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item        (w_pop_item),
        .i_queue_empty (w_queue.empty),
        .o_pop         (w_pop),
        .o_busy        (w_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (w_result)
    );

    assign o_out_kind      = w_result.kind;
    assign o_out_byte      = w_result.byte_val;
    assign o_status        = w_result.status;
    assign o_payload_count = w_result.count;
    assign o_last          = w_result.last;

    // The queue never holds more than its depth.
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("item queue level beyond its depth");

    // A running header sequence always produces a byte once the output moves.
    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy && (!o_out_valid || !i_out_stall)) |=> o_out_valid)
        else $error("transmit sequence gave no byte");

    // Nothing is taken from the queue while a header sequence runs.
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_pop)
        else $error("queue popped during transmit sequence");

endmodule

>>> hdl/afp_front.sv
// ----------------------------------------------------------------------------
// afp_front: input register and classifier
// Takes input transactions, decodes the kind and hands classified items to
// the queue. Items of an unused kind are taken and dropped here.
// ----------------------------------------------------------------------------
module afp_front
    import afp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_data_byte,
    input  logic [15:0]   i_tx_count,
    input  t_queue_status i_queue,
    output logic          o_push,
    output t_item         o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;
    logic  w_keep;
    t_op   w_op;

    assign o_in_stall = r_valid && i_queue.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_queue.full;
    assign o_item     = r_item;

    always_comb begin
        w_keep = 1'b1;
        w_op   = OP_RX;
        unique case (i_kind)
            KIND_RX:      w_op = OP_RX;
            KIND_BEGIN:   w_op = OP_BEGIN;
            KIND_PAYLOAD: w_op = OP_PAY;
            default:      w_keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op    <= w_op;
            r_item.data  <= i_data_byte;
            r_item.count <= i_tx_count;
        end
    end

endmodule

>>> hdl/afp_queue.sv
// ----------------------------------------------------------------------------
// afp_queue: short item queue
// Circular buffer of classified items between the front and the back.
// ----------------------------------------------------------------------------
module afp_queue
    import afp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_level        = r_count;
    assign o_item         = r_mem[r_rd_ptr];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hdl/afp_back.sv
// ----------------------------------------------------------------------------
// afp_back: frame execution unit
// Runs the receive parser and the transmit framer on queued items and keeps
// the result in an output register. A begin item runs a header sequence of
// one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module afp_back
    import afp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_item       i_item,
    input  logic        i_queue_empty,
    output logic        o_pop,
    output logic        o_busy,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_result
);

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CHECK  = 5'b10000
    } t_phase;

    localparam logic [4:0] STEP_DELIM    = 5'd0;
    localparam logic [4:0] STEP_LEN_HI   = 5'd1;
    localparam logic [4:0] STEP_LEN_LO   = 5'd2;
    localparam logic [4:0] STEP_TYPE     = 5'd3;
    localparam logic [4:0] STEP_ID       = 5'd4;
    localparam logic [4:0] STEP_ADDR0    = 5'd5;
    localparam logic [4:0] STEP_ADDR7    = 5'd12;
    localparam logic [4:0] STEP_SHORT_HI = 5'd13;
    localparam logic [4:0] STEP_SHORT_LO = 5'd14;
    localparam logic [4:0] STEP_RADIUS   = 5'd15;
    localparam logic [4:0] STEP_OPTIONS  = 5'd16;
    localparam logic [4:0] STEP_CHK      = 5'd17;

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_rsum, n_rsum;
    logic [15:0] r_pidx, n_pidx;
    logic        r_skip, n_skip;
    logic [63:0] r_laddr, n_laddr;
    logic [15:0] r_saddr, n_saddr;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_tsum, n_tsum;
    logic        r_busy, n_busy;
    logic [4:0]  r_step, n_step;
    logic        r_out_valid;
    t_result     r_result;

    logic        w_out_free;
    logic        w_emit;
    t_result     w_res;
    logic [15:0] w_tx_len;
    logic [2:0]  w_lane;
    logic [7:0]  w_b;
    logic        w_skip_now;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_busy      = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign w_tx_len    = r_rem + TX_HEADER_LEN;
    assign w_lane      = 3'(STEP_ADDR7 - r_step);
    assign w_b         = i_item.data;
    assign w_skip_now  = r_skip || ((r_seen == '0) && (w_b != i_cfg.rx_frame_type));

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_seen  = r_seen;
        n_rsum  = r_rsum;
        n_pidx  = r_pidx;
        n_skip  = r_skip;
        n_laddr = r_laddr;
        n_saddr = r_saddr;
        n_rem   = r_rem;
        n_tsum  = r_tsum;
        n_busy  = r_busy;
        n_step  = r_step;
        o_pop   = 1'b0;
        w_emit  = 1'b0;
        w_res   = '0;

        if (w_out_free && r_busy) begin
            // Header or closing checksum of a transmit frame.
            w_emit       = 1'b1;
            w_res.kind   = OUT_SEND;
            n_step       = r_step + 1'b1;
            case (r_step) inside
                STEP_DELIM:                w_res.byte_val = i_cfg.start_delimiter;
                STEP_LEN_HI:               w_res.byte_val = w_tx_len[15:8];
                STEP_LEN_LO:               w_res.byte_val = w_tx_len[7:0];
                STEP_TYPE:                 w_res.byte_val = i_cfg.tx_frame_type;
                [STEP_ADDR0:STEP_ADDR7]:   w_res.byte_val = r_laddr[{w_lane, 3'b000} +: 8];
                STEP_SHORT_HI:             w_res.byte_val = r_saddr[15:8];
                STEP_SHORT_LO:             w_res.byte_val = r_saddr[7:0];
                STEP_CHK:                  w_res.byte_val = CHECK_TARGET - r_tsum;
                default:                   w_res.byte_val = PAD_BYTE;
            endcase
            if (r_step >= STEP_TYPE && r_step <= STEP_OPTIONS) begin
                n_tsum = r_tsum + w_res.byte_val;
            end
            if (r_step == STEP_OPTIONS) begin
                if (r_rem == '0) begin
                    n_step = STEP_CHK;
                end else begin
                    n_busy     = 1'b0;
                    w_res.last = 1'b1;
                end
            end else if (r_step == STEP_CHK) begin
                n_busy     = 1'b0;
                w_res.last = 1'b1;
            end
        end else if (w_out_free && !i_queue_empty) begin
            o_pop = 1'b1;
            unique case (i_item.op)
                OP_BEGIN: begin
                    n_tsum         = '0;
                    n_rem          = i_item.count;
                    n_busy         = 1'b1;
                    n_step         = STEP_LEN_HI;
                    w_emit         = 1'b1;
                    w_res.kind     = OUT_SEND;
                    w_res.byte_val = i_cfg.start_delimiter;
                end
                OP_PAY: begin
                    if (r_rem != '0) begin
                        w_emit         = 1'b1;
                        w_res.kind     = OUT_SEND;
                        w_res.byte_val = w_b;
                        n_tsum         = r_tsum + w_b;
                        n_rem          = r_rem - 1'b1;
                        if (r_rem == 16'd1) begin
                            // Checksum follows as the next output byte.
                            n_busy = 1'b1;
                            n_step = STEP_CHK;
                        end else begin
                            w_res.last = 1'b1;
                        end
                    end
                end
                default: begin
                    unique case (r_phase)
                        PH_LEN_HI: begin
                            n_len   = {w_b, 8'h00};
                            n_phase = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            n_len   = {r_len[15:8], w_b};
                            n_seen  = '0;
                            n_rsum  = '0;
                            n_pidx  = '0;
                            n_skip  = 1'b0;
                            n_phase = ({r_len[15:8], w_b} != '0) ? PH_DATA : PH_HUNT;
                        end
                        PH_DATA: begin
                            n_rsum = r_rsum + w_b;
                            n_skip = w_skip_now;
                            n_seen = r_seen + 1'b1;
                            if (r_seen + 1'b1 >= r_len) begin
                                n_phase = PH_CHECK;
                            end
                            if (!w_skip_now) begin
                                for (int i = 0; i < 8; i++) begin
                                    if (r_seen == 16'(8 - i)) begin
                                        n_laddr[8*i +: 8] = w_b;
                                    end
                                end
                                if (r_seen == 16'd9) begin
                                    n_saddr[15:8] = w_b;
                                end
                                if (r_seen == 16'd10) begin
                                    n_saddr[7:0] = w_b;
                                end
                                if (r_seen >= RX_PAYLOAD_OFS) begin
                                    w_emit     = 1'b1;
                                    w_res.last = 1'b1;
                                    if (r_pidx < i_cfg.max_payload) begin
                                        n_pidx         = r_pidx + 1'b1;
                                        w_res.kind     = OUT_PAYLOAD;
                                        w_res.byte_val = w_b;
                                    end else begin
                                        // Buffer full: report and resync.
                                        w_res.kind   = OUT_STATUS;
                                        w_res.status = ST_OVERFLOW;
                                        n_phase      = PH_HUNT;
                                    end
                                end
                            end
                        end
                        PH_CHECK: begin
                            n_phase = PH_HUNT;
                            if (!r_skip) begin
                                w_emit     = 1'b1;
                                w_res.kind = OUT_STATUS;
                                w_res.last = 1'b1;
                                if (8'(r_rsum + w_b) == CHECK_TARGET) begin
                                    w_res.status = ST_PASS;
                                    w_res.count  = r_pidx;
                                end else begin
                                    w_res.status = ST_CHKFAIL;
                                end
                            end
                        end
                        default: begin
                            n_phase = (w_b == i_cfg.start_delimiter) ? PH_LEN_HI : PH_HUNT;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len       <= '0;
            r_seen      <= '0;
            r_rsum      <= '0;
            r_pidx      <= '0;
            r_skip      <= 1'b0;
            r_laddr     <= '0;
            r_saddr     <= '0;
            r_rem       <= '0;
            r_tsum      <= '0;
            r_busy      <= 1'b0;
            r_step      <= STEP_DELIM;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_rsum  <= n_rsum;
            r_pidx  <= n_pidx;
            r_skip  <= n_skip;
            r_laddr <= n_laddr;
            r_saddr <= n_saddr;
            r_rem   <= n_rem;
            r_tsum  <= n_tsum;
            r_busy  <= n_busy;
            r_step  <= n_step;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit) begin
            r_result <= w_res;
        end
    end

endmodule

>>> bench/tb_api_frame_rx_parser_tx_framer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_api_frame_rx_parser_tx_framer: self-checking bench for the API frame
// receive parser and transmit framer.
// Received frames (good, wrong type, truncated, bad checksum, overflowing),
// transmit frames and stray traffic are queued up and driven under random
// idling on both sides. A behavioural copy of the parser and framer predicts
// every result, and each result is compared field by field on arrival. The
// registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_api_frame_rx_parser_tx_framer;
    import afp_pkg::*;

    localparam int          QUIET_LIMIT        = 2000;
    localparam int          SETTLE_CYCLES      = 8;
    localparam int          RANDOM_PER_SETTING = 40;
    localparam logic [1:0]  KIND_UNUSED        = 2'd3;

    typedef enum logic [2:0] {
        SEEK_DELIM,
        LEN_HIGH,
        LEN_LOW,
        IN_BODY,
        AT_CHECKSUM
    } parse_state_e;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] count;
        bit          drain_first;
    } link_item_t;

    // Block ports.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_kind          = KIND_RX;
    logic [7:0]           i_data_byte     = 8'h00;
    logic [15:0]          i_tx_count      = 16'h0000;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic [1:0]           o_out_kind;
    logic [7:0]           o_out_byte;
    logic [1:0]           o_status;
    logic [15:0]          o_payload_count;
    logic                 o_last;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_MAX_PAYLOAD;
    logic [15:0]          i_cfg_data      = 16'h0000;

    // Register copies.
    logic [15:0]  cfg_max_payload = RST_MAX_PAYLOAD;
    logic [7:0]   cfg_delim       = RST_START_DELIMITER;
    logic [7:0]   cfg_rx_type     = RST_RX_FRAME_TYPE;
    logic [7:0]   cfg_tx_type     = RST_TX_FRAME_TYPE;

    // Parser and framer state as predicted.
    parse_state_e prs_phase       = SEEK_DELIM;
    logic [15:0]  frm_len         = '0;
    logic [15:0]  body_count      = '0;
    logic [7:0]   body_sum        = '0;
    logic [15:0]  pay_count       = '0;
    logic         skipping        = 1'b0;
    logic [63:0]  peer_long_addr  = '0;
    logic [15:0]  peer_short_addr = '0;
    logic [15:0]  tx_left         = '0;
    logic [7:0]   tx_csum         = '0;

    link_item_t   pending_items[$];
    t_result      awaited_results[$];
    t_result      step_batch[$];
    bit           hold_for_drain   = 1'b0;

    int sender_idle_pct   = 23;
    int receiver_idle_pct = 59;
    int error_count       = 0;
    int items_accepted    = 0;
    int results_checked   = 0;
    int rx_frames_built   = 0;
    int tx_frames_built   = 0;
    int settings_used     = 1;
    int quiet_cycles      = 0;

    api_frame_rx_parser_tx_framer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_data_byte     (i_data_byte),
        .i_tx_count      (i_tx_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_kind      (o_out_kind),
        .o_out_byte      (o_out_byte),
        .o_status        (o_status),
        .o_payload_count (o_payload_count),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void queue_result(logic [1:0] k, logic [7:0] b, logic [1:0] st,
                                         logic [15:0] c);
        t_result r;
        r.kind     = k;
        r.byte_val = b;
        r.status   = st;
        r.count    = c;
        r.last     = 1'b0;
        step_batch.push_back(r);
    endfunction

    function automatic void queue_summed(logic [7:0] b);
        tx_csum = tx_csum + b;
        queue_result(OUT_SEND, b, ST_PASS, 16'd0);
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        logic [7:0] total;
        case (prs_phase)
            LEN_HIGH: begin
                frm_len   = {b, 8'h00};
                prs_phase = LEN_LOW;
            end
            LEN_LOW: begin
                frm_len[7:0] = b;
                body_count   = '0;
                body_sum     = '0;
                pay_count    = '0;
                skipping     = 1'b0;
                prs_phase    = (frm_len != 0) ? IN_BODY : SEEK_DELIM;
            end
            IN_BODY: begin
                body_sum = body_sum + b;
                if (body_count == 0 && b != cfg_rx_type) begin
                    skipping = 1'b1;
                end
                if (!skipping) begin
                    if (body_count >= 1 && body_count <= 8) begin
                        peer_long_addr[(8 - int'(body_count)) * 8 +: 8] = b;
                    end else if (body_count == 9) begin
                        peer_short_addr[15:8] = b;
                    end else if (body_count == 10) begin
                        peer_short_addr[7:0] = b;
                    end else if (body_count >= RX_PAYLOAD_OFS) begin
                        if (pay_count < cfg_max_payload) begin
                            pay_count++;
                            queue_result(OUT_PAYLOAD, b, ST_PASS, 16'd0);
                        end else begin
                            // Buffer full: report it and go back to hunting.
                            prs_phase = SEEK_DELIM;
                            queue_result(OUT_STATUS, 8'h00, ST_OVERFLOW, 16'd0);
                            return;
                        end
                    end
                end
                body_count++;
                if (body_count >= frm_len) begin
                    prs_phase = AT_CHECKSUM;
                end
            end
            AT_CHECKSUM: begin
                prs_phase = SEEK_DELIM;
                total     = body_sum + b;
                if (!skipping) begin
                    if (total == CHECK_TARGET) begin
                        queue_result(OUT_STATUS, 8'h00, ST_PASS, pay_count);
                    end else begin
                        queue_result(OUT_STATUS, 8'h00, ST_CHKFAIL, 16'd0);
                    end
                end
            end
            default: begin
                prs_phase = (b == cfg_delim) ? LEN_HIGH : SEEK_DELIM;
            end
        endcase
    endfunction

    function automatic void predict_link_outputs(logic [1:0] kind, logic [7:0] b,
                                                 logic [15:0] cnt);
        logic [15:0] tx_len;
        step_batch.delete();
        case (kind)
            KIND_RX: begin
                parse_rx_byte(b);
            end
            KIND_BEGIN: begin
                tx_len  = TX_HEADER_LEN + cnt;
                tx_csum = '0;
                tx_left = cnt;
                queue_result(OUT_SEND, cfg_delim, ST_PASS, 16'd0);
                queue_result(OUT_SEND, tx_len[15:8], ST_PASS, 16'd0);
                queue_result(OUT_SEND, tx_len[7:0], ST_PASS, 16'd0);
                queue_summed(cfg_tx_type);
                queue_summed(PAD_BYTE);
                for (int i = 7; i >= 0; i--) begin
                    queue_summed(peer_long_addr[i * 8 +: 8]);
                end
                queue_summed(peer_short_addr[15:8]);
                queue_summed(peer_short_addr[7:0]);
                queue_summed(PAD_BYTE);
                queue_summed(PAD_BYTE);
                if (tx_left == 0) begin
                    queue_result(OUT_SEND, CHECK_TARGET - tx_csum, ST_PASS, 16'd0);
                end
            end
            KIND_PAYLOAD: begin
                if (tx_left != 0) begin
                    queue_summed(b);
                    tx_left--;
                    if (tx_left == 0) begin
                        queue_result(OUT_SEND, CHECK_TARGET - tx_csum, ST_PASS, 16'd0);
                    end
                end
            end
            default: ;
        endcase
        if (step_batch.size() != 0) begin
            step_batch[step_batch.size() - 1].last = 1'b1;
        end
        foreach (step_batch[i]) begin
            awaited_results.push_back(step_batch[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    function automatic void push_item(logic [1:0] k, logic [7:0] d, logic [15:0] c);
        link_item_t it;
        it.kind        = k;
        it.data        = d;
        it.count       = c;
        it.drain_first = hold_for_drain;
        hold_for_drain = 1'b0;
        pending_items.push_back(it);
    endfunction

    // Now and then a transmit payload byte slips in between received bytes.
    function automatic void push_rx_byte(logic [7:0] b);
        if ($urandom_range(24) == 0) begin
            push_item(KIND_PAYLOAD, 8'($urandom), 16'($urandom));
        end
        push_item(KIND_RX, b, 16'($urandom));
    endfunction

    function automatic logic [7:0] not_delim(logic [7:0] b);
        return (b == cfg_delim) ? (b ^ 8'h01) : b;
    endfunction

    function automatic void queue_rx_frame();
        logic [7:0]  body[$];
        logic [7:0]  body_total;
        logic [7:0]  chk;
        logic [15:0] len;
        int          n_pay;
        int          flavour;
        int          keep;
        bit          spills;
        flavour = $urandom_range(99);
        n_pay   = ($urandom_range(11) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 4);
        if (flavour < 10) begin
            body.push_back(cfg_rx_type ^ 8'($urandom_range(1, 255)));
        end else begin
            body.push_back(cfg_rx_type);
        end
        repeat (11) body.push_back(8'($urandom));
        spills = (flavour >= 18) && (n_pay > cfg_max_payload);
        // After an overflow the parser hunts through the rest of the frame, so a
        // delimiter there would swallow the following frames.
        for (int i = 0; i < n_pay; i++) begin
            if (spills && i >= cfg_max_payload) begin
                body.push_back(not_delim(8'($urandom)));
            end else begin
                body.push_back(8'($urandom));
            end
        end
        if (flavour >= 10 && flavour < 18) begin
            keep = $urandom_range(0, 11);
            while (body.size() > keep) void'(body.pop_back());
        end
        len        = 16'(body.size());
        body_total = '0;
        foreach (body[i]) body_total = body_total + body[i];
        chk = CHECK_TARGET - body_total;
        if (flavour >= 18 && flavour < 28) begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        if (spills) begin
            chk = not_delim(chk);
        end
        push_rx_byte(cfg_delim);
        push_rx_byte(len[15:8]);
        push_rx_byte(len[7:0]);
        foreach (body[i]) push_rx_byte(body[i]);
        if (len != 0) begin
            push_rx_byte(chk);
        end
        rx_frames_built++;
    endfunction

    function automatic void queue_tx_frame();
        int          n_pay;
        int          n_sent;
        logic [15:0] cnt;
        n_pay  = $urandom_range(0, 5);
        cnt    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(n_pay);
        n_sent = ($urandom_range(7) == 0) ? $urandom_range(0, n_pay) : n_pay;
        push_item(KIND_BEGIN, 8'($urandom), cnt);
        repeat (n_sent) push_item(KIND_PAYLOAD, 8'($urandom), 16'($urandom));
        tx_frames_built++;
    endfunction

    function automatic void queue_noise();
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(2))
                0:       push_item(KIND_RX, not_delim(8'($urandom)), 16'($urandom));
                1:       push_item(KIND_UNUSED, 8'($urandom), 16'($urandom));
                default: push_item(KIND_PAYLOAD, 8'($urandom), 16'($urandom));
            endcase
        end
    endfunction

    function automatic void queue_random_traffic(int budget);
        int sent;
        int start_size;
        int pick;
        sent           = 0;
        hold_for_drain = 1'b1;
        while (sent < budget) begin
            start_size = pending_items.size();
            pick       = $urandom_range(99);
            if (pick < 55) begin
                queue_rx_frame();
                sent += pending_items.size() - start_size;
            end else if (pick < 85) begin
                queue_tx_frame();
                sent += pending_items.size() - start_size;
            end else begin
                queue_noise();
            end
            if ($urandom_range(49) == 0) begin
                hold_for_drain = 1'b1;
            end
        end
    endfunction

    function automatic void queue_directed_items();
        push_item(KIND_UNUSED, 8'hFF, 16'hFFFF);
        push_item(KIND_PAYLOAD, 8'h00, 16'h0000);   // nothing outstanding
        push_item(KIND_BEGIN, 8'h00, 16'd0);        // checksum right after header
        push_item(KIND_BEGIN, 8'hFF, 16'd2);
        push_item(KIND_PAYLOAD, 8'hFF, 16'hFFFF);
        push_item(KIND_BEGIN, 8'h00, 16'd1);        // restarts the open frame
        push_item(KIND_PAYLOAD, 8'hA5, 16'h0000);
        push_item(KIND_PAYLOAD, 8'h5A, 16'h0000);
        push_item(KIND_BEGIN, 8'h00, 16'hFFFF);     // length field wraps
        push_item(KIND_BEGIN, 8'h00, 16'd0);
        push_item(KIND_RX, RST_START_DELIMITER, 16'h0000);
        push_item(KIND_RX, 8'h00, 16'h0000);
        push_item(KIND_RX, 8'h00, 16'h0000);        // zero length frame
        push_item(KIND_RX, RST_START_DELIMITER, 16'h0000);
        push_item(KIND_RX, 8'h00, 16'h0000);
        push_item(KIND_RX, 8'h01, 16'h0000);
        push_item(KIND_RX, 8'h12, 16'h0000);        // foreign type, skipped
        push_item(KIND_RX, 8'h00, 16'h0000);
    endfunction

    // ------------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------------
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || awaited_results.size() != 0);
        // Received bytes can leave the block busy with no result owed.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_PAYLOAD:     cfg_max_payload = val;
            CFG_START_DELIMITER: cfg_delim       = val[7:0];
            CFG_RX_FRAME_TYPE:   cfg_rx_type     = val[7:0];
            CFG_TX_FRAME_TYPE:   cfg_tx_type     = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [15:0] max_pay, logic [7:0] delim, logic [7:0] rx_type,
                                 logic [7:0] tx_type);
        write_register(CFG_MAX_PAYLOAD, max_pay);
        write_register(CFG_START_DELIMITER, {8'h00, delim});
        write_register(CFG_RX_FRAME_TYPE, {8'h00, rx_type});
        write_register(CFG_TX_FRAME_TYPE, {8'h00, tx_type});
        settings_used++;
        @(negedge i_clk);
    endtask

    initial begin : phase_sequence
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_directed_items();
        queue_random_traffic(RANDOM_PER_SETTING);
        wait_until_drained();

        apply_setting(16'd6, 8'h7E, 8'h90, 8'h10);
        queue_random_traffic(RANDOM_PER_SETTING);
        wait_until_drained();

        sender_idle_pct   = 59;
        receiver_idle_pct = 23;
        apply_setting(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
        queue_random_traffic(RANDOM_PER_SETTING);
        wait_until_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        apply_setting(16'd3, 8'h00, 8'hFF, 8'h00);
        queue_random_traffic(RANDOM_PER_SETTING);
        wait_until_drained();

        apply_setting(16'($urandom_range(0, 12)), 8'($urandom), 8'($urandom), 8'($urandom));
        queue_random_traffic(RANDOM_PER_SETTING);
        wait_until_drained();

        $display("Run covered %0d input transactions (%0d receive frames, %0d transmit frames)",
                 items_accepted, rx_frames_built, tx_frames_built);
        $display("under %0d register settings; %0d result transactions checked.",
                 settings_used, results_checked);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : input_driver
        link_item_t next_item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_link_outputs(i_kind, i_data_byte, i_tx_count);
                items_accepted++;
            end
            // A stalled transaction is held as it is.
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                    !(pending_items[0].drain_first && awaited_results.size() != 0)) begin
                    next_item   = pending_items.pop_front();
                    i_in_valid  <= 1'b1;
                    i_kind      <= next_item.kind;
                    i_data_byte <= next_item.data;
                    i_tx_count  <= next_item.count;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                flag_error($sformatf("unexpected result kind %0d byte %02h status %0d",
                                     o_out_kind, o_out_byte, o_status));
            end else begin
                want = awaited_results.pop_front();
                if (o_out_kind !== want.kind)
                    flag_error($sformatf("result %0d out_kind %0d, wanted %0d",
                                         results_checked, o_out_kind, want.kind));
                if (o_out_byte !== want.byte_val)
                    flag_error($sformatf("result %0d out_byte %02h, wanted %02h",
                                         results_checked, o_out_byte, want.byte_val));
                if (o_status !== want.status)
                    flag_error($sformatf("result %0d status %0d, wanted %0d",
                                         results_checked, o_status, want.status));
                if (o_payload_count !== want.count)
                    flag_error($sformatf("result %0d payload_count %0d, wanted %0d",
                                         results_checked, o_payload_count, want.count));
                if (o_last !== want.last)
                    flag_error($sformatf("result %0d last %0b, wanted %0b",
                                         results_checked, o_last, want.last));
            end
        end
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: any accepted transaction on any channel counts as progress.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : progress_watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", awaited_results.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> api_frame_rx_parser_tx_framer.f
hdl/afp_pkg.sv
hdl/afp_front.sv
hdl/afp_queue.sv
hdl/afp_back.sv
hdl/api_frame_rx_parser_tx_framer.sv
bench/tb_api_frame_rx_parser_tx_framer.sv
